// ===== design/vef_pkg.sv =====
// shared types, codes and constants of the volume envelope follower
`timescale 1ns / 1ps
package vef_pkg;

  // input transaction
  typedef struct packed {
    logic signed [31:0] time_stamp;
    logic        [15:0] mixed_volume;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
  } vef_in_t;

  // result transaction
  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic        [15:0] level;
  } vef_out_t;

  // configuration register indexes
  localparam logic [1:0] REG_SCALE_LOW  = 2'd0;
  localparam logic [1:0] REG_SCALE_HIGH = 2'd1;
  localparam logic [1:0] REG_APPLY_MASK = 2'd2;

  localparam logic signed [31:0] SCALE_LOW_RST  = 32'sd0;
  localparam logic signed [31:0] SCALE_HIGH_RST = 32'sd65536;
  localparam logic        [2:0]  APPLY_MASK_RST = 3'd0;
  localparam logic signed [31:0] LAST_TIME_RST  = -32'sd65536;

  localparam logic [15:0] ONE_Q15   = 16'd32768;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [49:0] ROUND_Q15 = 50'd16384;

  localparam int MAC_A_W   = 18;
  localparam int MAC_B_W   = 33;
  localparam int MAC_ACC_W = 50;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WEIGHT,
    ST_BLEND_A,
    ST_BLEND_B,
    ST_LEVEL,
    ST_MAP,
    ST_SUM,
    ST_DONE
  } vef_state_t;

  // operand select of the shared multiply-accumulate unit
  typedef enum logic [1:0] {
    MSEL_VOL_W,
    MSEL_LVL_INV_W,
    MSEL_MAP
  } vef_msel_t;

  // sequencer to datapath
  typedef struct packed {
    logic      ready;
    logic      ld_weight;
    logic      ld_keep;
    logic      mac_en;
    logic      mac_accum;
    vef_msel_t mac_sel;
    logic      ld_level;
    logic      ld_mapped;
    logic      ld_out;
  } vef_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic same_time;
    logic out_free;
  } vef_stat_t;

endpackage

// ===== design/vef_mac.sv =====
// shared multiply-accumulate unit with registered accumulator
`timescale 1ns / 1ps
module vef_mac (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  accum,
  input  logic signed [vef_pkg::MAC_A_W-1:0]    op_a,
  input  logic signed [vef_pkg::MAC_B_W-1:0]    op_b,
  input  logic signed [vef_pkg::MAC_ACC_W-1:0]  op_c,
  output logic signed [vef_pkg::MAC_ACC_W-1:0]  acc
);
  import vef_pkg::*;

  logic signed [MAC_A_W+MAC_B_W-1:0] prod;
  logic signed [MAC_ACC_W-1:0]       base;
  logic signed [MAC_ACC_W-1:0]       acc_r;
  logic signed [MAC_ACC_W-1:0]       acc_nxt;

  always_comb begin
    prod    = op_a * op_b;
    base    = accum ? acc_r : '0;
    acc_nxt = base + prod[MAC_ACC_W-1:0] + op_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== design/vef_seq.sv =====
// sequencer that steps one transaction through the shared unit
`timescale 1ns / 1ps
module vef_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  vef_pkg::vef_stat_t stat,
  output vef_pkg::vef_ctrl_t ctrl
);
  import vef_pkg::*;

  vef_state_t state_r;
  vef_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    ctrl.mac_sel = MSEL_VOL_W;
    case (state_r)
      ST_IDLE: begin
        ctrl.ready = 1'b1;
        if (stat.in_valid) begin
          state_nxt = ST_WEIGHT;
        end
      end
      ST_WEIGHT: begin
        if (stat.same_time) begin
          ctrl.ld_keep = 1'b1;
          state_nxt    = ST_MAP;
        end else begin
          ctrl.ld_weight = 1'b1;
          state_nxt      = ST_BLEND_A;
        end
      end
      ST_BLEND_A: begin
        ctrl.mac_en  = 1'b1;
        ctrl.mac_sel = MSEL_VOL_W;
        state_nxt    = ST_BLEND_B;
      end
      ST_BLEND_B: begin
        ctrl.mac_en    = 1'b1;
        ctrl.mac_accum = 1'b1;
        ctrl.mac_sel   = MSEL_LVL_INV_W;
        state_nxt      = ST_LEVEL;
      end
      ST_LEVEL: begin
        ctrl.ld_level = 1'b1;
        state_nxt     = ST_MAP;
      end
      ST_MAP: begin
        ctrl.mac_en  = 1'b1;
        ctrl.mac_sel = MSEL_MAP;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        ctrl.ld_mapped = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          ctrl.ld_out = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/volume_envelope_follower.sv =====
// top level of the attack/release volume envelope follower
// One transaction is taken whenever the block is idle and is worked through a single
// multiply-accumulate unit under a small sequencer. A transaction whose time stamp
// equals the stored one goes from acceptance to the result register through accept,
// compare, map multiply, map add and output load; a new time stamp also needs the two
// blend products, run in turn on the shared unit before the mapping product, with a
// level update step in between. The block is not ready until the result is loaded.
// The result waits in an output register, so a stalled result holds back only the
// final step of the next transaction. Configuration writes are always taken
// (cfg_ready is tied high); a write to an index past the register list is dropped.
// Writes are meant for an idle block.
`timescale 1ns / 1ps
module volume_envelope_follower (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  vef_pkg::vef_in_t in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output vef_pkg::vef_out_t out_data,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import vef_pkg::*;

  // configuration registers
  logic signed [31:0] scale_low_r;
  logic signed [31:0] scale_high_r;
  logic        [2:0]  apply_mask_r;

  // follower state
  logic signed [31:0] last_time_r;
  logic        [15:0] last_level_r;

  // transaction registers
  logic signed [31:0] time_r;
  logic        [15:0] vol_r;
  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic signed [31:0] z_r;
  logic        [15:0] weight_r;
  logic        [15:0] level_r;
  logic signed [31:0] mapped_r;

  // output register
  logic     out_valid_r;
  vef_out_t out_data_r;

  vef_ctrl_t ctrl;
  vef_stat_t stat;

  logic in_take;
  logic cfg_take;

  // weight path
  logic signed [32:0] tdiff;
  logic        [32:0] tdist;
  logic        [16:0] tdist_lo;
  logic        [20:0] wprod;
  logic        [16:0] w16;
  logic               attack;
  logic        [15:0] vol_clamp;

  // shared unit operands
  logic signed [MAC_A_W-1:0]   mac_a;
  logic signed [MAC_B_W-1:0]   mac_b;
  logic signed [MAC_ACC_W-1:0] mac_c;
  logic signed [MAC_ACC_W-1:0] mac_acc;

  logic [16:0] blend_lvl;
  logic [15:0] blend_lvl_sat;

  logic signed [32:0] x_sum;
  logic signed [32:0] y_sum;
  logic signed [32:0] z_sum;
  vef_out_t           res;

  // saturate a 33-bit sum into the signed 32-bit range
  function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  assign in_take  = in_valid && ctrl.ready;
  assign in_stall = !ctrl.ready;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;

  assign stat.in_valid  = in_valid;
  assign stat.same_time = (time_r == last_time_r);
  assign stat.out_free  = !out_valid_r || !out_stall;

  vef_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // volumes above 1.0 saturate to 1.0
  assign vol_clamp = (in_data.mixed_volume > ONE_Q15) ? ONE_Q15 : in_data.mixed_volume;

  // blend weight: |dt| times 12 on attack, times 8 on release, clamped to 1.0
  always_comb begin
    tdiff    = {time_r[31], time_r} - {last_time_r[31], last_time_r};
    tdist    = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
    tdist_lo = tdist[16:0];
    attack   = vol_r > last_level_r;
    wprod    = attack ? ({tdist_lo, 3'b000} + {1'b0, tdist_lo, 2'b00}) + 21'd0
                      : {1'b0, tdist_lo, 3'b000};
    if (tdist[32:17] != '0 || wprod > {4'd0, ONE_Q16}) begin
      w16 = ONE_Q16;
    end else begin
      w16 = wprod[16:0];
    end
  end

  // operand select for the shared multiply-accumulate unit
  always_comb begin
    case (ctrl.mac_sel)
      MSEL_VOL_W: begin
        mac_a = {2'b00, vol_r};
        mac_b = {17'd0, weight_r};
        mac_c = ROUND_Q15;
      end
      MSEL_LVL_INV_W: begin
        mac_a = {2'b00, last_level_r};
        mac_b = {17'd0, ONE_Q15 - weight_r};
        mac_c = '0;
      end
      MSEL_MAP: begin
        mac_a = {2'b00, level_r};
        mac_b = {scale_high_r[31], scale_high_r} - {scale_low_r[31], scale_low_r};
        mac_c = '0;
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
        mac_c = '0;
      end
    endcase
  end

  vef_mac u_mac (
    .clk   (clk),
    .en    (ctrl.mac_en),
    .accum (ctrl.mac_accum),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .op_c  (mac_c),
    .acc   (mac_acc)
  );

  // blended level, rounded half up, kept at or below 1.0
  assign blend_lvl     = mac_acc[31:15];
  assign blend_lvl_sat = (blend_lvl > {1'b0, ONE_Q15}) ? ONE_Q15 : blend_lvl[15:0];

  // saturating adds into the selected outputs
  always_comb begin
    x_sum = {x_r[31], x_r} + {mapped_r[31], mapped_r};
    y_sum = {y_r[31], y_r} + {mapped_r[31], mapped_r};
    z_sum = {z_r[31], z_r} + {mapped_r[31], mapped_r};
    res.x_out = apply_mask_r[0] ? sat33(x_sum) : x_r;
    res.y_out = apply_mask_r[1] ? sat33(y_sum) : y_r;
    res.z_out = apply_mask_r[2] ? sat33(z_sum) : z_r;
    res.level = level_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_low_r  <= SCALE_LOW_RST;
      scale_high_r <= SCALE_HIGH_RST;
      apply_mask_r <= APPLY_MASK_RST;
    end else if (cfg_take) begin
      case (cfg_index)
        REG_SCALE_LOW:  scale_low_r  <= cfg_wdata;
        REG_SCALE_HIGH: scale_high_r <= cfg_wdata;
        REG_APPLY_MASK: apply_mask_r <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // follower state, updated only on a new time stamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r  <= LAST_TIME_RST;
      last_level_r <= '0;
    end else if (ctrl.ld_level) begin
      last_time_r  <= time_r;
      last_level_r <= blend_lvl_sat;
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      time_r <= in_data.time_stamp;
      vol_r  <= vol_clamp;
      x_r    <= in_data.x_in;
      y_r    <= in_data.y_in;
      z_r    <= in_data.z_in;
    end
    if (ctrl.ld_weight) begin
      weight_r <= w16[16:1];
    end
    if (ctrl.ld_keep) begin
      level_r <= last_level_r;
    end else if (ctrl.ld_level) begin
      level_r <= blend_lvl_sat;
    end
    // floor of level times span over 1.0, plus the low bound
    if (ctrl.ld_mapped) begin
      mapped_r <= scale_low_r + mac_acc[46:15];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the block goes busy right after taking a transaction
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in flight");

  // the stored level never exceeds 1.0
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_level_r <= ONE_Q15)
    else $error("stored level above 1.0");

  // a result is only loaded while the block is not taking input
  a_load_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ld_out |-> in_stall)
    else $error("result loaded while taking input");

endmodule

// ===== test/volume_envelope_follower_tb.sv =====
// self-checking testbench of the volume envelope follower with its own level predictor
`timescale 1ns / 1ps
module volume_envelope_follower_tb;
  import vef_pkg::*;

  // fixed point anchors of the predictor
  localparam longint LVL_ONE      = 32768;
  localparam longint WEIGHT_ONE   = 65536;
  localparam longint ATTACK_GAIN  = 12;
  localparam longint RELEASE_GAIN = 8;
  localparam longint HALF_LSB     = 16384;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // first index past the register list, writes to it are dropped
  localparam logic [1:0] REG_NONE = 2'd3;

  localparam int PRINT_CAP       = 40;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int SETTLE_CYCLES   = 20;

  // block ports, every input known from time zero
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  vef_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  vef_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SCALE_LOW;
  logic [31:0] cfg_wdata = '0;

  // predictor copy of the registers and of the follower state
  logic signed [31:0] map_low;
  logic signed [31:0] map_high;
  logic        [2:0]  add_mask;
  logic signed [31:0] env_time;
  logic        [15:0] env_level;

  // predicted results, oldest first
  vef_out_t pending_results[$];

  int  errors       = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  reg_writes   = 0;
  bit  in_gaps_on   = 1'b0;
  bit  stall_enable = 1'b0;
  int  stall_left   = 0;

  volume_envelope_follower uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // signed 32-bit saturating sum
  function automatic logic signed [31:0] sat_sum(input longint base, input longint delta);
    longint total;
    total = base + delta;
    if (total > longint'(S32_MAX)) total = longint'(S32_MAX);
    if (total < longint'(S32_MIN)) total = longint'(S32_MIN);
    return total[31:0];
  endfunction

  // envelope follower predictor: updates the state and returns the result transaction
  function automatic vef_out_t follow_envelope(input vef_in_t item);
    vef_out_t res;
    longint   vol;
    longint   prev;
    longint   span;
    longint   w16;
    longint   wt;
    longint   acc;
    longint   lvl;
    longint   mapped;
    vol  = longint'(item.mixed_volume);
    if (vol > LVL_ONE) vol = LVL_ONE;  // volume above 1.0 clips
    prev = longint'(env_level);
    if ($signed(item.time_stamp) == env_time) begin
      // same date: reuse the stored level, state untouched
      lvl = prev;
    end else begin
      span = longint'($signed(item.time_stamp)) - longint'(env_time);
      if (span < 0) span = -span;
      // strict compare, a volume equal to the level releases
      w16 = span * ((vol > prev) ? ATTACK_GAIN : RELEASE_GAIN);
      if (w16 > WEIGHT_ONE) w16 = WEIGHT_ONE;
      wt  = w16 >>> 1;
      acc = vol * wt + prev * (LVL_ONE - wt) + HALF_LSB;
      lvl = acc >>> 15;
      if (lvl > LVL_ONE) lvl = LVL_ONE;
      env_level = lvl[15:0];
      env_time  = item.time_stamp;
    end
    // linear map between the bounds, floor of the scaled span
    mapped = longint'(map_low) +
             ((lvl * (longint'(map_high) - longint'(map_low))) >>> 15);
    res.x_out = add_mask[0] ? sat_sum(item.x_in, mapped) : item.x_in;
    res.y_out = add_mask[1] ? sat_sum(item.y_in, mapped) : item.y_in;
    res.z_out = add_mask[2] ? sat_sum(item.z_in, mapped) : item.z_in;
    res.level = lvl[15:0];
    return res;
  endfunction

  function automatic vef_in_t make_item(input logic signed [31:0] t, input logic [15:0] v,
                                        input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z);
    vef_in_t item;
    item.time_stamp   = t;
    item.mixed_volume = v;
    item.x_in         = x;
    item.y_in         = y;
    item.z_in         = z;
    return item;
  endfunction

  // running value: mostly anything, sometimes close to a rail
  function automatic logic signed [31:0] random_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom;
    if (roll < 88) return S32_MAX - $urandom_range(0, 70000);
    return S32_MIN + $urandom_range(0, 70000);
  endfunction

  // mostly a plausible timeline: small forward steps, repeats, some jumps
  function automatic vef_in_t random_item();
    vef_in_t item;
    int      roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) item.time_stamp = env_time;
    else if (roll < 65) item.time_stamp = env_time + $urandom_range(1, 6000);
    else if (roll < 75) item.time_stamp = env_time - $urandom_range(1, 3000);
    else if (roll < 88) item.time_stamp = env_time + $urandom_range(6000, 400000);
    else item.time_stamp = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 40) item.mixed_volume = 16'($urandom_range(0, 32768));
    else if (roll < 52) item.mixed_volume = 16'd0;
    else if (roll < 64) item.mixed_volume = 16'd32768;
    else if (roll < 76) item.mixed_volume = env_level;
    else if (roll < 86) item.mixed_volume = 16'(env_level + $urandom_range(0, 2) - 1);
    else item.mixed_volume = 16'($urandom_range(0, 65535));
    item.x_in = random_word();
    item.y_in = random_word();
    item.z_in = random_word();
    return item;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t: mismatch on %s: got %0d, wanted %0d", $time, what, got, want);
  endtask

  // one input transaction; valid stays up across back-to-back items
  task automatic send_item(input vef_in_t item);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(follow_envelope(item));
    items_sent++;
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_SCALE_LOW:  map_low  = value;
      REG_SCALE_HIGH: map_high = value;
      REG_APPLY_MASK: add_mask = value[2:0];
      default: ;  // past the register list, dropped
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic wait_drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() > 0) begin
      report_mismatch("results never delivered", pending_results.size(), 0);
      pending_results.delete();
    end
  endtask

  // default registers add nothing, only the level moves
  task automatic test_reset_state();
    // date equals the reset date: level held at zero
    send_item(make_item(LAST_TIME_RST, 16'd32768, 32'sd100, -32'sd100, S32_MAX));
    // one second on with full volume: weight clips, level jumps to 1.0
    send_item(make_item(32'sd0, 16'd32768, S32_MIN, 32'sd0, 32'sd1));
    // same date again with silence: level stays at 1.0
    send_item(make_item(32'sd0, 16'd0, 32'sd7, S32_MIN, -32'sd7));
    wait_drain();
  endtask

  // widest bounds drive the sums into both rails
  task automatic test_saturation();
    write_reg(REG_SCALE_LOW, S32_MIN);
    write_reg(REG_SCALE_HIGH, S32_MAX);
    write_reg(REG_APPLY_MASK, 32'd7);
    // volume above 1.0 clips to 1.0, equal to the level so release, map hits the top
    send_item(make_item(32'sd65536, 16'hffff, S32_MAX, 32'sd1, S32_MIN));
    // full release to zero, map hits the bottom
    send_item(make_item(32'sd196608, 16'd0, S32_MIN, S32_MAX, 32'sd0));
    wait_drain();
  endtask

  // blend weights from tiny to clipped, attack and release, time running backward
  task automatic test_weights();
    write_reg(REG_SCALE_LOW, 32'sd0);
    write_reg(REG_SCALE_HIGH, 32'sd65536);
    write_reg(REG_APPLY_MASK, 32'd1);
    send_item(make_item(32'sd196609, 16'd32768, 32'sd0, 32'sd5, 32'sd6));   // smallest step
    send_item(make_item(32'sd199339, 16'd32768, 32'sd10, 32'sd0, 32'sd0));  // about half
    send_item(make_item(32'sd199339, 16'd0, 32'sd0, 32'sd0, 32'sd0));       // same date
    // volume equal to the level takes the release path
    send_item(make_item(32'sd199439, env_level, -32'sd65536, 32'sd0, 32'sd0));
    send_item(make_item(32'sd199389, 16'd0, 32'sd1, 32'sd2, 32'sd3));       // backward
    send_item(make_item(S32_MAX, 16'd32768, S32_MAX, 32'sd0, 32'sd0));      // huge attack
    send_item(make_item(S32_MIN, 16'd0, S32_MIN, 32'sd0, 32'sd0));          // widest gap
    send_item(make_item(S32_MIN + 32'sd3, 16'd20000, 32'sd0, 32'sd0, 32'sd0));
    wait_drain();
  endtask

  // bounds swapped so the span is negative, plus a dropped write
  task automatic test_bounds();
    write_reg(REG_SCALE_LOW, 32'sd196608);
    write_reg(REG_SCALE_HIGH, -32'sd327680);
    write_reg(REG_NONE, 32'hffff_ffff);
    // only the low mask bits count
    write_reg(REG_APPLY_MASK, 32'hffff_fffa);
    send_item(make_item(S32_MIN + 32'sd800, 16'd12345, 32'sd0, 32'sd0, 32'sd0));
    send_item(make_item(S32_MIN + 32'sd900, 16'd1, 32'sd0, S32_MIN, 32'sd0));
    send_item(make_item(S32_MIN + 32'sd3000, 16'd32767, 32'sd0, 32'sd9, 32'sd0));
    send_item(make_item(S32_MIN + 32'sd3000, 16'd32769, 32'sd0, -32'sd9, 32'sd0));
    wait_drain();
  endtask

  task automatic run_random_phase(input logic signed [31:0] low,
                                  input logic signed [31:0] high,
                                  input logic [31:0] mask, input bit gaps, input bit stalls);
    write_reg(REG_SCALE_LOW, low);
    write_reg(REG_SCALE_HIGH, high);
    write_reg(REG_APPLY_MASK, mask);
    in_gaps_on   = gaps;
    stall_enable <= stalls;
    repeat (ITEMS_PER_PHASE) send_item(random_item());
    wait_drain();
  endtask

  // random timelines under several register settings and idling patterns
  task automatic test_random();
    run_random_phase(32'sd0, 32'sd65536, 32'd7, 1'b0, 1'b0);     // full rate both sides
    run_random_phase(S32_MIN, S32_MAX, 32'd7, 1'b1, 1'b1);
    run_random_phase(S32_MAX, S32_MIN, 32'd5, 1'b1, 1'b0);
    run_random_phase(-32'sd262144, 32'sd262144, 32'd2, 1'b0, 1'b1);
    write_reg(REG_NONE, $urandom);
    run_random_phase($urandom, $urandom, $urandom, 1'b1, 1'b1);
    run_random_phase(-32'sd1, 32'sd1, 32'd6, 1'b1, 1'b1);        // floor on a tiny span
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (!stall_enable) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    vef_out_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_data.level, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.x_out !== want.x_out) report_mismatch("x_out", out_data.x_out, want.x_out);
        if (out_data.y_out !== want.y_out) report_mismatch("y_out", out_data.y_out, want.y_out);
        if (out_data.z_out !== want.z_out) report_mismatch("z_out", out_data.z_out, want.z_out);
        if (out_data.level !== want.level) report_mismatch("level", out_data.level, want.level);
      end
      results_seen++;
    end
  end

  initial begin
    // predictor starts from the reset state
    map_low   = SCALE_LOW_RST;
    map_high  = SCALE_HIGH_RST;
    add_mask  = APPLY_MASK_RST;
    env_time  = LAST_TIME_RST;
    env_level = '0;
    repeat (5) @(posedge clk);
    rst_n        <= 1'b1;
    in_gaps_on   = 1'b1;
    stall_enable <= 1'b1;

    test_reset_state();
    test_saturation();
    test_weights();
    test_bounds();
    test_random();

    // let any stray result show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() > 0)
      report_mismatch("results left over", pending_results.size(), 0);

    $display("run covered %0d transactions in, %0d results out, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("attack, release, repeated dates, clipped volume, rail saturation, %0d errors",
             errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout: transactions stopped moving");
    $display("TEST FAILED");
    $finish;
  end

endmodule
